// ----- hw/rtl/chm_pkg.sv -----
// Package with the constants, codes and types of the chained hash map.
package chm_pkg;
	localparam int MAX_ENTRIES = 1024;
	localparam int MAX_BUCKETS = 4096;
	localparam int MIN_BUCKETS = 16;
	localparam int EW = $clog2(MAX_ENTRIES);
	localparam int LW = EW + 1;
	localparam int BW = $clog2(MAX_BUCKETS);
	localparam int CW = BW + 1;
	localparam logic [LW-1:0] NIL = LW'(MAX_ENTRIES);

	typedef enum logic [1:0] {
		OP_SET = 2'd0,
		OP_GET = 2'd1,
		OP_REM = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_SETF, S_SETW, S_LINK, S_LINKW, S_WALKH, S_WALKE, S_WALKC,
		S_UNLINK, S_RHCLR, S_RHB, S_RHBW, S_RHE, S_RHEW, S_RHCPR, S_RHCPW, S_OUT
	} state_t;

	// The smallest power of two not below floor(cnt*40/17), kept within the bucket limits.
	function automatic logic [CW-1:0] target_buckets(input logic [LW-1:0] cnt);
		logic [19:0] prod;
		logic [CW-1:0] p;
		prod = 20'(cnt) * 20'd40;
		p = CW'(MAX_BUCKETS);
		for (int i = BW; i >= $clog2(MIN_BUCKETS); i--) begin
			if (prod < 20'(17 * (1 << i) + 17))
				p = CW'(1 << i);
		end
		return p;
	endfunction
endpackage

// ----- hw/rtl/chm_ram.sv -----
// Generic single-port-write, one-read synchronous RAM with registered read.
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- hw/rtl/chained_hash_map_with_resize_core.sv -----
// Top level of the chained hash map: control sequencer around its memories.
//  channel | direction | fields
//  in      | input     | func, item_key, item_hash, item_value
//  out     | output    | status, found_value, entry_count, bucket_count
// An unknown operation goes straight to the result, a set into a full pool after the free
// pool read, a set after entry write and link, get and remove after a chain walk (a remove
// then unlinks). A resize rehash clears the new heads, moves every entry, copies heads back.
// After reset a clearing pass over all 4096 bucket heads empties them before any item.
// Input is taken only in idle with no result waiting; the result holds while out_ready is low.
module chained_hash_map_with_resize_core import chm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [31:0] item_key,
	input  logic [31:0] item_hash,
	input  logic [31:0] item_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] found_value,
	output logic [10:0] entry_count,
	output logic [12:0] bucket_count
);
	state_t st_q, st_d;
	logic [1:0] op_q;
	logic [31:0] key_q, hash_q, val_q;
	logic [LW-1:0] used_q, hw_q, e_q, prev_q, nx_q, newe_q, steps_q;
	logic [CW-1:0] nb_q, tnb_q, i_q;
	logic [BW-1:0] b_q;
	logic rh_set_q;
	logic out_valid_q;
	status_t status_q;
	logic [31:0] fv_q;

	// Two head tables: live and scratch for the rehash.
	logic hw_we, sw_we;
	logic [BW-1:0] hw_a, hr_a, sw_a, sr_a;
	logic [LW-1:0] hw_d, hr_q, sw_d, sr_q;
	logic nx_we, ent_we, fp_we;
	logic [EW-1:0] nx_wa, nx_ra, ent_wa, ent_ra, fp_wa, fp_ra;
	logic [LW-1:0] nx_wd, nx_rq, fp_wd, fp_rq;
	logic [95:0] ent_wd, ent_rq;

	chm_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_heads (.clk, .we(hw_we), .waddr(hw_a),
		.wdata(hw_d), .raddr(hr_a), .rdata(hr_q));
	chm_ram #(.WIDTH(LW), .DEPTH(MAX_BUCKETS)) u_newh (.clk, .we(sw_we), .waddr(sw_a),
		.wdata(sw_d), .raddr(sr_a), .rdata(sr_q));
	chm_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_next (.clk, .we(nx_we), .waddr(nx_wa),
		.wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rq));
	chm_ram #(.WIDTH(96), .DEPTH(MAX_ENTRIES)) u_ent (.clk, .we(ent_we), .waddr(ent_wa),
		.wdata(ent_wd), .raddr(ent_ra), .rdata(ent_rq));
	chm_ram #(.WIDTH(LW), .DEPTH(MAX_ENTRIES)) u_free (.clk, .we(fp_we), .waddr(fp_wa),
		.wdata(fp_wd), .raddr(fp_ra), .rdata(fp_rq));

	// A free pool slot at a count never reached before still holds its own index.
	logic [EW-1:0] slot;
	logic [LW-1:0] fp_val;
	assign slot = EW'(LW'(MAX_ENTRIES - 1) - used_q);
	assign fp_val = (used_q < hw_q) ? fp_rq : {1'b0, slot};

	logic [BW-1:0] bidx, rbidx;
	logic [31:0] e_key, e_hash, e_val;
	logic hit;
	assign e_key = ent_rq[95:64];
	assign e_hash = ent_rq[63:32];
	assign e_val = ent_rq[31:0];
	assign bidx = hash_q[BW-1:0] & BW'(nb_q - 1'b1);
	assign rbidx = e_hash[BW-1:0] & BW'(tnb_q - 1'b1);
	assign hit = (e_hash == hash_q) && (e_key == key_q);

	logic grow, shrink;
	logic [CW-1:0] tgt_set, tgt_rem;
	logic last_old, last_new, walk_stop, rh_stop;
	assign grow = ((16'(used_q) + 16'd1) * 16'd4) > (16'(nb_q) * 16'd3);
	assign shrink = ((16'(used_q) - 16'd1) * 16'd10) < 16'(nb_q);
	assign tgt_set = target_buckets(used_q + 1'b1);
	assign tgt_rem = target_buckets(used_q - 1'b1);
	assign last_old = (i_q + 1'b1) == nb_q;
	assign last_new = (i_q + 1'b1) == tnb_q;
	assign walk_stop = (nx_rq == NIL) || (steps_q == LW'(MAX_ENTRIES - 1));
	assign rh_stop = (nx_q == NIL) || (steps_q == LW'(MAX_ENTRIES - 1));

	assign in_ready = (st_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign status = status_q;
	assign found_value = fv_q;
	assign entry_count = used_q;
	assign bucket_count = nb_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			S_CLR: if (i_q == CW'(MAX_BUCKETS - 1)) st_d = S_IDLE;
			S_IDLE: if (in_valid && in_ready) begin
				if (func == OP_SET) st_d = S_SETF;
				else if (func == OP_GET || func == OP_REM) st_d = S_WALKH;
				else st_d = S_OUT;
			end
			S_SETF: st_d = (used_q == LW'(MAX_ENTRIES)) ? S_OUT : S_SETW;
			S_SETW: st_d = (grow && tgt_set != nb_q) ? S_RHCLR : S_LINK;
			S_LINK: st_d = S_LINKW;
			S_LINKW: st_d = S_OUT;
			S_WALKH: st_d = S_WALKE;
			S_WALKE: st_d = (hr_q == NIL) ? S_OUT : S_WALKC;
			S_WALKC: begin
				if (hit) st_d = (op_q == OP_REM) ? S_UNLINK : S_OUT;
				else if (walk_stop) st_d = S_OUT;
			end
			S_UNLINK: st_d = (shrink && tgt_rem != nb_q) ? S_RHCLR : S_OUT;
			S_RHCLR: if (last_new) st_d = S_RHB;
			S_RHB: st_d = S_RHBW;
			S_RHBW: begin
				if (hr_q != NIL) st_d = S_RHE;
				else st_d = last_old ? S_RHCPR : S_RHB;
			end
			S_RHE: st_d = S_RHEW;
			S_RHEW: begin
				if (!rh_stop) st_d = S_RHE;
				else st_d = last_old ? S_RHCPR : S_RHB;
			end
			S_RHCPR: st_d = S_RHCPW;
			S_RHCPW: if (last_new) st_d = rh_set_q ? S_LINK : S_OUT;
				else st_d = S_RHCPR;
			S_OUT: st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		hw_we = 1'b0; hw_a = BW'(i_q); hw_d = NIL; hr_a = bidx;
		sw_we = 1'b0; sw_a = BW'(i_q); sw_d = NIL; sr_a = BW'(i_q);
		nx_we = 1'b0; nx_wa = EW'(e_q); nx_wd = sr_q; nx_ra = EW'(e_q);
		ent_we = 1'b0; ent_wa = EW'(newe_q); ent_wd = {key_q, hash_q, val_q};
		ent_ra = EW'(e_q);
		fp_we = 1'b0; fp_wa = EW'(LW'(MAX_ENTRIES) - used_q); fp_wd = e_q; fp_ra = slot;
		case (st_q)
			S_CLR: hw_we = 1'b1;
			S_SETW: ent_we = 1'b1;
			S_LINKW: begin
				nx_we = 1'b1; nx_wa = EW'(newe_q); nx_wd = hr_q;
				hw_we = 1'b1; hw_a = bidx; hw_d = newe_q;
			end
			S_WALKE: begin nx_ra = EW'(hr_q); ent_ra = EW'(hr_q); end
			S_WALKC: begin nx_ra = EW'(nx_rq); ent_ra = EW'(nx_rq); end
			S_UNLINK: begin
				if (prev_q != NIL) begin
					nx_we = 1'b1; nx_wa = EW'(prev_q); nx_wd = nx_q;
				end else begin
					hw_we = 1'b1; hw_a = b_q; hw_d = nx_q;
				end
				fp_we = 1'b1;
			end
			S_RHCLR: sw_we = 1'b1;
			S_RHB: hr_a = BW'(i_q);
			S_RHBW: begin nx_ra = EW'(hr_q); ent_ra = EW'(hr_q); end
			S_RHE: sr_a = rbidx;
			S_RHEW: begin
				nx_we = 1'b1;
				sw_we = 1'b1; sw_a = b_q; sw_d = e_q;
				nx_ra = EW'(nx_q); ent_ra = EW'(nx_q);
			end
			S_RHCPW: begin hw_we = 1'b1; hw_d = sr_q; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR; i_q <= '0; used_q <= '0; hw_q <= '0;
			nb_q <= CW'(MIN_BUCKETS); tnb_q <= CW'(MIN_BUCKETS);
			out_valid_q <= 1'b0; status_q <= ST_MISS; fv_q <= '0; rh_set_q <= 1'b0;
			op_q <= '0; key_q <= '0; hash_q <= '0; val_q <= '0;
			e_q <= NIL; prev_q <= NIL; nx_q <= NIL; newe_q <= '0; steps_q <= '0; b_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == S_OUT) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (st_q)
				S_CLR: i_q <= i_q + 1'b1;
				S_IDLE: if (in_valid && in_ready) begin
					op_q <= func; key_q <= item_key; hash_q <= item_hash; val_q <= item_value;
					status_q <= ST_MISS; fv_q <= '0;
				end
				S_SETF: begin
					newe_q <= fp_val;
					if (used_q == LW'(MAX_ENTRIES)) status_q <= ST_FULL;
				end
				S_SETW: begin
					used_q <= used_q + 1'b1;
					if (used_q + 1'b1 > hw_q) hw_q <= used_q + 1'b1;
					status_q <= ST_OK; fv_q <= val_q;
					tnb_q <= tgt_set; rh_set_q <= 1'b1; i_q <= '0;
				end
				S_WALKH: begin
					b_q <= bidx; prev_q <= NIL; steps_q <= '0;
				end
				S_WALKE: e_q <= hr_q;
				S_WALKC: begin
					if (hit) begin
						status_q <= ST_OK; fv_q <= e_val; nx_q <= nx_rq;
					end else begin
						prev_q <= e_q; e_q <= nx_rq; steps_q <= steps_q + 1'b1;
					end
				end
				S_UNLINK: begin
					used_q <= used_q - 1'b1;
					tnb_q <= tgt_rem; rh_set_q <= 1'b0; i_q <= '0;
				end
				S_RHCLR: i_q <= last_new ? '0 : i_q + 1'b1;
				S_RHBW: begin
					e_q <= hr_q; steps_q <= '0;
					if (hr_q == NIL) i_q <= last_old ? '0 : i_q + 1'b1;
				end
				S_RHE: begin
					b_q <= rbidx; nx_q <= nx_rq;
				end
				S_RHEW: begin
					e_q <= nx_q; steps_q <= steps_q + 1'b1;
					if (rh_stop) i_q <= last_old ? '0 : i_q + 1'b1;
				end
				S_RHCPW: begin
					i_q <= i_q + 1'b1;
					if (last_new) nb_q <= tnb_q;
				end
				default: ;
			endcase
		end
	end

	property p_ready_idle;
		@(posedge clk) disable iff (!arst_n) in_ready |-> st_q == S_IDLE;
	endproperty
	assert property (p_ready_idle) else $error("ready outside idle");
	assert property (@(posedge clk) disable iff (!arst_n) used_q <= LW'(MAX_ENTRIES))
		else $error("count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) $onehot(nb_q))
		else $error("bucket count not a power of two");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(found_value))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped while stalled");
endmodule
